/* rtl/core/rma_pkg.sv */
// shared types, codes and constant tables of the rotation matrix accumulator
`timescale 1ns / 1ps

package rma_pkg;

   // command codes on the request channel
   localparam logic [1:0] CMD_ROT_X    = 2'd0;
   localparam logic [1:0] CMD_ROT_Y    = 2'd1;
   localparam logic [1:0] CMD_ROT_AXIS = 2'd2;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   // command classes handed from the front end to the engine
   localparam logic [2:0] KIND_ROT_X     = 3'd0;
   localparam logic [2:0] KIND_ROT_Y     = 3'd1;
   localparam logic [2:0] KIND_ROT_AXIS  = 3'd2;
   localparam logic [2:0] KIND_ZERO_AXIS = 3'd3;
   localparam logic [2:0] KIND_NOP       = 3'd4;

   localparam int CORDIC_STEPS = 30;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] angle;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
      logic               zero_axis;
   } rsp_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [15:0] angle;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
   } work_type;

   // arctangent of 2^-i as a 32-bit binary angle
   function automatic logic [31:0] atan_value(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

/* rtl/core/rotation_matrix_accumulator_unit.sv */
// top level of the rotation matrix accumulator
`timescale 1ns / 1ps

// Keeps a 3x3 orientation matrix (row-major, signed, FRAC_BITS fraction bits,
// identity after reset) and premultiplies it by a rotation about X, about Y
// (sine signs transposed), or about an arbitrary normalized axis for each
// request beat, returning all nine entries after the update. A command-2 beat
// with a zero axis, and an unused command code, leave the matrix as it is;
// the zero-axis case raises zero_axis. One request is worked at a time by a
// sequencer that shares a single multiplier: X and Y rotations run 30 CORDIC
// iterations and 27 multiplies, an axis rotation adds the squares, the
// 32-step square root, three bit-serial divisions and 15 Rodrigues
// multiplies, and a beat that leaves the matrix alone goes straight to the
// result write. Two request beats and two result beats can wait in the
// queues on either side of the engine.
module rotation_matrix_accumulator_unit #(
   parameter int FRAC_BITS  = 14,
   parameter int ANGLE_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  rma_pkg::req_type req_data,
   input  logic             push,
   output logic             full,
   output rma_pkg::rsp_type rsp_data,
   output logic             empty,
   input  logic             pop
);

   // front end to engine
   rma_pkg::work_type work;
   logic              work_valid;
   logic              work_take;

   // engine to result queue
   rma_pkg::rsp_type  core_rsp;
   logic              core_rsp_push;
   logic              rsp_fifo_full;

   // classify and queue incoming beats
   rma_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .push       (push),
      .full       (full),
      .work       (work),
      .work_valid (work_valid),
      .work_take  (work_take)
   );

   // matrix engine
   rma_core #(
      .FRAC_BITS  (FRAC_BITS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .work       (work),
      .work_valid (work_valid),
      .work_take  (work_take),
      .rsp        (core_rsp),
      .rsp_push   (core_rsp_push),
      .rsp_full   (rsp_fifo_full)
   );

   // result beats wait here until popped
   rma_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_data  (core_rsp),
      .wr_push  (core_rsp_push),
      .wr_full  (rsp_fifo_full),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

   // the engine never drops a result into a full queue
   assert property (@(posedge clock) disable iff (reset) core_rsp_push |-> !rsp_fifo_full)
      else $error("result pushed into full queue");

   // the engine only takes work that is there
   assert property (@(posedge clock) disable iff (reset) work_take |-> work_valid)
      else $error("work taken from empty queue");

   // no result is shown right after reset
   assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

endmodule

/* rtl/core/rma_front.sv */
// front end: takes request beats, classifies them and queues them for the engine
`timescale 1ns / 1ps

module rma_front (
   input  logic              clock,
   input  logic              reset,
   input  rma_pkg::req_type  req_data,
   input  logic              push,
   output logic              full,
   output rma_pkg::work_type work,
   output logic              work_valid,
   input  logic              work_take
);

   rma_pkg::work_type entry_ff [2];
   rma_pkg::work_type entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign work_valid = (count_ff != 2'd0);
   assign work       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = work_take && work_valid;

   always_comb begin
      entry_in.angle  = req_data.angle;
      entry_in.axis_x = req_data.axis_x;
      entry_in.axis_y = req_data.axis_y;
      entry_in.axis_z = req_data.axis_z;
      unique case (req_data.cmd)
         rma_pkg::CMD_ROT_X: entry_in.kind = rma_pkg::KIND_ROT_X;
         rma_pkg::CMD_ROT_Y: entry_in.kind = rma_pkg::KIND_ROT_Y;
         rma_pkg::CMD_ROT_AXIS: begin
            if (req_data.axis_x == 16'sd0 && req_data.axis_y == 16'sd0 &&
                req_data.axis_z == 16'sd0)
               entry_in.kind = rma_pkg::KIND_ZERO_AXIS;
            else
               entry_in.kind = rma_pkg::KIND_ROT_AXIS;
         end
         default: entry_in.kind = rma_pkg::KIND_NOP;
      endcase
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= entry_in;
   end

endmodule

/* rtl/core/rma_rsp_fifo.sv */
// two-entry result queue between the engine and the result channel
`timescale 1ns / 1ps

module rma_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  rma_pkg::rsp_type wr_data,
   input  logic             wr_push,
   output logic             wr_full,
   output rma_pkg::rsp_type rsp_data,
   output logic             empty,
   input  logic             pop
);

   rma_pkg::rsp_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign wr_full  = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rsp_data = slot_ff[rd_ptr_ff];
   assign do_push  = wr_push && !wr_full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

/* rtl/core/rma_core.sv */
// back end: sine/cosine, axis normalization, rotation build and premultiply
`timescale 1ns / 1ps

module rma_core #(
   parameter int FRAC_BITS  = 14,
   parameter int ANGLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  rma_pkg::work_type work,
   input  logic              work_valid,
   output logic              work_take,
   output rma_pkg::rsp_type  rsp,
   output logic              rsp_push,
   input  logic              rsp_full
);

   localparam int EW = FRAC_BITS + 2;
   localparam int MW = (FRAC_BITS + 3 > 17) ? FRAC_BITS + 3 : 17;
   localparam int PW = 2 * MW;
   localparam int AW = PW + 2;
   localparam int QW = FRAC_BITS + 2;
   localparam int DW = FRAC_BITS + 33;
   localparam int CS = 30 - FRAC_BITS;
   localparam int ASH = 32 - ANGLE_BITS;

   localparam logic signed [MW-1:0] ONE_M = MW'(64'd1 << FRAC_BITS);
   localparam logic signed [EW-1:0] ONE_E = EW'(64'd1 << FRAC_BITS);
   localparam logic [QW-1:0] ONE_Q = QW'(64'd1 << FRAC_BITS);
   localparam logic signed [34:0] RND_C = 35'((64'd1 << CS) >> 1);
   localparam logic signed [PW-1:0] RND_P = PW'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [AW-1:0] RND_A = AW'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [AW-1:0] SAT_HI = AW'((64'd1 << (FRAC_BITS + 1)) - 64'd1);
   localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
   localparam logic signed [33:0] QUARTER = 34'sd1073741824;
   localparam logic signed [33:0] HALF = 34'sd2147483648;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CORDIC = 4'd1;
   localparam logic [3:0] S_TRIG   = 4'd2;
   localparam logic [3:0] S_SQ     = 4'd3;
   localparam logic [3:0] S_SQRT   = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_ROD    = 4'd6;
   localparam logic [3:0] S_BUILD  = 4'd7;
   localparam logic [3:0] S_PRE    = 4'd8;
   localparam logic [3:0] S_COMMIT = 4'd9;
   localparam logic [3:0] S_WRITE  = 4'd10;

   function automatic logic signed [EW-1:0] clamp_one(input logic signed [MW:0] v);
      logic signed [EW-1:0] r;
      if (v > (MW+1)'(ONE_M))       r = ONE_E;
      else if (v < -((MW+1)'(ONE_M))) r = -ONE_E;
      else                            r = EW'(v);
      return r;
   endfunction

   function automatic logic [15:0] angle_bits(input logic signed [15:0] a);
      return a;
   endfunction

   logic [3:0] state_ff, state_in;
   logic [2:0] kind_ff, kind_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] ph_ff, ph_in;
   logic [1:0] comp_ff, comp_in;
   logic [1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;

   logic signed [15:0] ax_ff [3];
   logic signed [15:0] ax_in [3];
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic               neg_ff, neg_in;
   logic signed [MW-1:0] s_ff, s_in, c_ff, c_in;
   logic [31:0] n2_ff, n2_in;
   logic [63:0] sn_ff, sn_in, sr_ff, sr_in, sb_ff, sb_in;
   logic [DW-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic signed [MW-1:0] ux_ff, ux_in, uy_ff, uy_in, uz_ff, uz_in;
   logic signed [MW-1:0] sv_ff [3];
   logic signed [MW-1:0] sv_in [3];
   logic signed [MW-1:0] q_ff [6];
   logic signed [MW-1:0] q_in [6];
   logic signed [EW-1:0] r_ff [9];
   logic signed [EW-1:0] r_in [9];
   logic signed [EW-1:0] or_ff [9];
   logic signed [EW-1:0] or_in [9];
   logic signed [EW-1:0] res_ff [9];
   logic signed [EW-1:0] res_in [9];
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [MW-1:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic signed [PW-1:0] mul_p_ff;

   // combinational helpers
   logic [31:0]        th;
   logic signed [33:0] z0;
   logic signed [33:0] atan_s;
   logic [1:0]         ax_idx;
   logic signed [15:0] axis_rd;
   logic [16:0]        axis_mag;
   logic [30:0]        len;
   logic [63:0]        sq_trial;
   logic signed [34:0] xr, yr;
   logic signed [34:0] xsh, ysh;
   logic signed [PW-1:0] mq_full;
   logic signed [MW-1:0] mq;
   logic signed [MW-1:0] t_val;
   logic [QW-1:0]      quo_cl;
   logic [2:0]         qidx;
   logic [3:0]         ridx, oidx, eidx;
   logic signed [AW-1:0] acc_sum, acc_rnd;
   logic signed [EW-1:0] acc_sat;
   logic signed [MW:0]   rod [9];

   assign th       = 32'(64'({48'd0, angle_bits(work.angle)}) << ASH);
   assign atan_s   = $signed({2'b00, rma_pkg::atan_value(cnt_ff)});
   assign ax_idx   = (state_ff == S_SQ) ? cnt_ff[1:0] : comp_ff;
   assign axis_rd  = ax_ff[ax_idx];
   assign axis_mag = axis_rd[15] ? 17'(-{axis_rd[15], axis_rd}) : {1'b0, axis_rd};
   assign len      = sr_ff[30:0];
   assign sq_trial = sr_ff + sb_ff;
   assign xr       = neg_ff ? -35'(cx_ff) : 35'(cx_ff);
   assign yr       = neg_ff ? -35'(cy_ff) : 35'(cy_ff);
   assign xsh      = (xr + RND_C) >>> CS;
   assign ysh      = (yr + RND_C) >>> CS;
   assign mq_full  = (mul_p_ff + RND_P) >>> FRAC_BITS;
   assign mq       = MW'(mq_full);
   assign t_val    = ONE_M - c_ff;
   assign quo_cl   = (quo_ff > ONE_Q) ? ONE_Q : quo_ff;
   assign qidx     = (cnt_ff < 5'd9) ? 3'(cnt_ff - 5'd3) : 3'(cnt_ff - 5'd9);
   assign ridx     = 4'(i_ff) * 4'd3 + 4'(k_ff);
   assign oidx     = 4'(k_ff) * 4'd3 + 4'(j_ff);
   assign eidx     = 4'(i_ff) * 4'd3 + 4'(j_ff);
   assign acc_sum  = acc_ff + AW'(mul_p_ff);
   assign acc_rnd  = (acc_sum + RND_A) >>> FRAC_BITS;
   assign acc_sat  = (acc_rnd > SAT_HI) ? EW'(SAT_HI) :
                     ((acc_rnd < SAT_LO) ? EW'(SAT_LO) : EW'(acc_rnd));

   // binary angle as a signed value; it is folded into the right half plane when the work is taken
   always_comb begin
      z0 = 34'($signed(th));
   end

   // rodrigues entries before clamping
   always_comb begin
      rod[0] = (MW+1)'(c_ff) + (MW+1)'(q_ff[0]);
      rod[1] = (MW+1)'(q_ff[3]) - (MW+1)'(sv_ff[2]);
      rod[2] = (MW+1)'(q_ff[4]) + (MW+1)'(sv_ff[1]);
      rod[3] = (MW+1)'(q_ff[3]) + (MW+1)'(sv_ff[2]);
      rod[4] = (MW+1)'(c_ff) + (MW+1)'(q_ff[1]);
      rod[5] = (MW+1)'(q_ff[5]) - (MW+1)'(sv_ff[0]);
      rod[6] = (MW+1)'(q_ff[4]) - (MW+1)'(sv_ff[1]);
      rod[7] = (MW+1)'(q_ff[5]) + (MW+1)'(sv_ff[0]);
      rod[8] = (MW+1)'(c_ff) + (MW+1)'(q_ff[2]);
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cnt_in   = cnt_ff;
      ph_in    = ph_ff;
      comp_in  = comp_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      ax_in    = ax_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      neg_in   = neg_ff;
      s_in     = s_ff;
      c_in     = c_ff;
      n2_in    = n2_ff;
      sn_in    = sn_ff;
      sr_in    = sr_ff;
      sb_in    = sb_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      ux_in    = ux_ff;
      uy_in    = uy_ff;
      uz_in    = uz_ff;
      sv_in    = sv_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      or_in    = or_ff;
      res_in   = res_ff;
      acc_in   = acc_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      work_take = 1'b0;
      rsp_push  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (work_valid) begin
               work_take = 1'b1;
               kind_in   = work.kind;
               ax_in[0]  = work.axis_x;
               ax_in[1]  = work.axis_y;
               ax_in[2]  = work.axis_z;
               cx_in     = rma_pkg::CORDIC_GAIN;
               cy_in     = 34'sd0;
               cnt_in    = 5'd0;
               if (z0 > QUARTER) begin
                  cz_in  = z0 - HALF;
                  neg_in = 1'b1;
               end else if (z0 < -QUARTER) begin
                  cz_in  = z0 + HALF;
                  neg_in = 1'b1;
               end else begin
                  cz_in  = z0;
                  neg_in = 1'b0;
               end
               if (work.kind == rma_pkg::KIND_NOP || work.kind == rma_pkg::KIND_ZERO_AXIS)
                  state_in = S_WRITE;
               else
                  state_in = S_CORDIC;
            end
         end
         S_CORDIC: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - (cy_ff >>> cnt_ff);
               cy_in = cy_ff + (cx_ff >>> cnt_ff);
               cz_in = cz_ff - atan_s;
            end else begin
               cx_in = cx_ff + (cy_ff >>> cnt_ff);
               cy_in = cy_ff - (cx_ff >>> cnt_ff);
               cz_in = cz_ff + atan_s;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(rma_pkg::CORDIC_STEPS - 1)) state_in = S_TRIG;
         end
         S_TRIG: begin
            c_in   = MW'(xsh);
            s_in   = MW'(ysh);
            cnt_in = 5'd0;
            ph_in  = 2'd0;
            n2_in  = 32'd0;
            if (kind_ff == rma_pkg::KIND_ROT_AXIS) state_in = S_SQ;
            else                                   state_in = S_BUILD;
         end
         S_SQ: begin
            // axis squares through the shared multiplier
            unique case (ph_ff)
               2'd0: begin
                  mul_a_in = MW'(axis_rd);
                  mul_b_in = MW'(axis_rd);
                  ph_in    = 2'd1;
               end
               2'd1: ph_in = 2'd2;
               default: begin
                  n2_in = n2_ff + mul_p_ff[31:0];
                  ph_in = 2'd0;
                  if (cnt_ff == 5'd2) begin
                     cnt_in   = 5'd0;
                     sn_in    = 64'(n2_in) << 30;
                     sr_in    = 64'd0;
                     sb_in    = 64'd1 << 62;
                     state_in = S_SQRT;
                  end else begin
                     cnt_in = cnt_ff + 5'd1;
                  end
               end
            endcase
         end
         S_SQRT: begin
            // one result bit per cycle
            if (sn_ff >= sq_trial) begin
               sn_in = sn_ff - sq_trial;
               sr_in = (sr_ff >> 1) + sb_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sb_in  = sb_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               comp_in  = 2'd0;
               ph_in    = 2'd0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            unique case (ph_ff)
               2'd0: begin
                  rem_in = (DW'(axis_mag) << (FRAC_BITS + 15)) + DW'(len >> 1);
                  dvs_in = DW'(len) << (QW - 1);
                  quo_in = '0;
                  cnt_in = 5'd0;
                  ph_in  = 2'd1;
               end
               2'd1: begin
                  if (rem_ff >= dvs_ff) begin
                     rem_in = rem_ff - dvs_ff;
                     quo_in = {quo_ff[QW-2:0], 1'b1};
                  end else begin
                     quo_in = {quo_ff[QW-2:0], 1'b0};
                  end
                  dvs_in = dvs_ff >> 1;
                  cnt_in = cnt_ff + 5'd1;
                  if (cnt_ff == 5'(QW - 1)) ph_in = 2'd2;
               end
               default: begin
                  unique case (comp_ff)
                     2'd0: ux_in = axis_rd[15] ? -MW'(quo_cl) : MW'(quo_cl);
                     2'd1: uy_in = axis_rd[15] ? -MW'(quo_cl) : MW'(quo_cl);
                     default: uz_in = axis_rd[15] ? -MW'(quo_cl) : MW'(quo_cl);
                  endcase
                  ph_in = 2'd0;
                  if (comp_ff == 2'd2) begin
                     cnt_in   = 5'd0;
                     state_in = S_ROD;
                  end else begin
                     comp_in = comp_ff + 2'd1;
                  end
               end
            endcase
         end
         S_ROD: begin
            // axis times sine, axis products, then products times one minus cosine
            unique case (ph_ff)
               2'd0: begin
                  unique case (cnt_ff)
                     5'd0, 5'd3, 5'd6, 5'd7: mul_a_in = ux_ff;
                     5'd1, 5'd4, 5'd8:       mul_a_in = uy_ff;
                     5'd2, 5'd5:             mul_a_in = uz_ff;
                     default:                mul_a_in = q_ff[qidx];
                  endcase
                  unique case (cnt_ff)
                     5'd0, 5'd1, 5'd2: mul_b_in = s_ff;
                     5'd3:             mul_b_in = ux_ff;
                     5'd4, 5'd6:       mul_b_in = uy_ff;
                     5'd5, 5'd7, 5'd8: mul_b_in = uz_ff;
                     default:          mul_b_in = t_val;
                  endcase
                  ph_in = 2'd1;
               end
               2'd1: ph_in = 2'd2;
               default: begin
                  if (cnt_ff < 5'd3) sv_in[cnt_ff[1:0]] = mq;
                  else               q_in[qidx] = mq;
                  ph_in = 2'd0;
                  if (cnt_ff == 5'd14) state_in = S_BUILD;
                  else                 cnt_in = cnt_ff + 5'd1;
               end
            endcase
         end
         S_BUILD: begin
            unique case (kind_ff)
               rma_pkg::KIND_ROT_X: begin
                  r_in[0] = ONE_E; r_in[1] = '0;        r_in[2] = '0;
                  r_in[3] = '0;    r_in[4] = EW'(c_ff); r_in[5] = -EW'(s_ff);
                  r_in[6] = '0;    r_in[7] = EW'(s_ff); r_in[8] = EW'(c_ff);
               end
               rma_pkg::KIND_ROT_Y: begin
                  r_in[0] = EW'(c_ff); r_in[1] = '0;    r_in[2] = -EW'(s_ff);
                  r_in[3] = '0;        r_in[4] = ONE_E; r_in[5] = '0;
                  r_in[6] = EW'(s_ff); r_in[7] = '0;    r_in[8] = EW'(c_ff);
               end
               default: begin
                  for (int e = 0; e < 9; e++) r_in[e] = clamp_one(rod[e]);
               end
            endcase
            i_in     = 2'd0;
            j_in     = 2'd0;
            k_in     = 2'd0;
            ph_in    = 2'd0;
            acc_in   = '0;
            state_in = S_PRE;
         end
         S_PRE: begin
            unique case (ph_ff)
               2'd0: begin
                  mul_a_in = MW'(r_ff[ridx]);
                  mul_b_in = MW'(or_ff[oidx]);
                  ph_in    = 2'd1;
               end
               2'd1: ph_in = 2'd2;
               default: begin
                  ph_in = 2'd0;
                  if (k_ff == 2'd2) begin
                     res_in[eidx] = acc_sat;
                     acc_in = '0;
                     k_in   = 2'd0;
                     if (j_ff == 2'd2) begin
                        j_in = 2'd0;
                        if (i_ff == 2'd2) state_in = S_COMMIT;
                        else              i_in = i_ff + 2'd1;
                     end else begin
                        j_in = j_ff + 2'd1;
                     end
                  end else begin
                     acc_in = acc_sum;
                     k_in   = k_ff + 2'd1;
                  end
               end
            endcase
         end
         S_COMMIT: begin
            or_in    = res_ff;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp.m00       = 16'(or_ff[0]);
   assign rsp.m01       = 16'(or_ff[1]);
   assign rsp.m02       = 16'(or_ff[2]);
   assign rsp.m10       = 16'(or_ff[3]);
   assign rsp.m11       = 16'(or_ff[4]);
   assign rsp.m12       = 16'(or_ff[5]);
   assign rsp.m20       = 16'(or_ff[6]);
   assign rsp.m21       = 16'(or_ff[7]);
   assign rsp.m22       = 16'(or_ff[8]);
   assign rsp.zero_axis = (kind_ff == rma_pkg::KIND_ZERO_AXIS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int e = 0; e < 9; e++)
            or_ff[e] <= (e % 4 == 0) ? ONE_E : '0;
      end else begin
         state_ff <= state_in;
         or_ff    <= or_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      cnt_ff   <= cnt_in;
      ph_ff    <= ph_in;
      comp_ff  <= comp_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      ax_ff    <= ax_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      neg_ff   <= neg_in;
      s_ff     <= s_in;
      c_ff     <= c_in;
      n2_ff    <= n2_in;
      sn_ff    <= sn_in;
      sr_ff    <= sr_in;
      sb_ff    <= sb_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
      ux_ff    <= ux_in;
      uy_ff    <= uy_in;
      uz_ff    <= uz_in;
      sv_ff    <= sv_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      res_ff   <= res_in;
      acc_ff   <= acc_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      mul_p_ff <= mul_a_ff * mul_b_ff;
   end

endmodule
